@@ src/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, codes and helpers shared by the round-robin task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int CNT_W = 16;
    localparam int TICK_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        OP_CREATE  = 4'd0,
        OP_KILL    = 4'd1,
        OP_YIELD   = 4'd2,
        OP_BLOCK   = 4'd3,
        OP_UNBLOCK = 4'd4,
        OP_BLKCUR  = 4'd5,
        OP_COLLECT = 4'd6,
        OP_QUERY   = 4'd7,
        OP_CLEAR   = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_IGNORE = 3'd1,
        STS_FULL   = 3'd2,
        STS_NORDY  = 3'd3,
        STS_NOIDS  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TS_RUNNING = 2'd0,
        TS_READY   = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DEAD    = 2'd3
    } t_tstate;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RUN,
        FSM_FINISH
    } t_fsm;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
    } t_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ src/rrts_if.sv @@
// ----------------------------------------------------------------------------
// rrts_if
// Valid/ready channels for scheduler commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrts_cmd_if #(parameter int ID_WIDTH = 16);
    logic                valid;
    logic                ready;
    logic [3:0]          op;
    logic [ID_WIDTH-1:0] task_id;

    modport source (output valid, output op, output task_id, input ready);
    modport sink   (input valid, input op, input task_id, output ready);
endinterface

interface rrts_res_if #(parameter int ID_WIDTH = 16, parameter int CW = 5);
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [ID_WIDTH-1:0] result_id;
    logic [ID_WIDTH-1:0] current_id;
    logic [1:0]          query_state;
    logic [15:0]         run_count;
    logic [15:0]         yield_total;
    logic [15:0]         block_total;
    logic [15:0]         wake_total;
    logic [31:0]         tick;
    logic [CW-1:0]       ready_count;
    logic [CW-1:0]       blocked_count;
    logic [CW-1:0]       dead_count;

    modport source (output valid, output status, output result_id, output current_id,
                    output query_state, output run_count, output yield_total,
                    output block_total, output wake_total, output tick,
                    output ready_count, output blocked_count, output dead_count,
                    input ready);
    modport sink   (input valid, input status, input result_id, input current_id,
                    input query_state, input run_count, input yield_total,
                    input block_total, input wake_total, input tick,
                    input ready_count, input blocked_count, input dead_count,
                    output ready);
endinterface

@@ src/round_robin_task_table_scheduler.sv @@
// Create, block current, clear and unknown op codes finish without a
// table walk; lookups, collect and yield walk up to used_slots entries,
// one slot per cycle, yield after first returning the running task.
// One command is in work at a time; the next is taken once its result is
// registered, even while that result still waits on the output.
// Reset (synchronous, active low) empties the table, invalidates the
// current slot, sets next id to one and clears the dispatch tick.
// ----------------------------------------------------------------------------
// round_robin_task_table_scheduler
// Task table with round-robin dispatch, kill, block, wake and compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_task_table_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int ID_WIDTH  = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    rrts_cmd_if.sink   i_cmd,
    rrts_res_if.source o_res
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int PW = $clog2(MAX_TASKS);

    t_cmd  cmd;
    t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rrts_dpath #(
        .MAX_TASKS (MAX_TASKS),
        .ID_WIDTH  (ID_WIDTH),
        .CW        (CW),
        .PW        (PW)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_cmd.op),
        .i_tid           (i_cmd.task_id),
        .o_stat          (stat),
        .o_status        (o_res.status),
        .o_result_id     (o_res.result_id),
        .o_current_id    (o_res.current_id),
        .o_query_state   (o_res.query_state),
        .o_run_count     (o_res.run_count),
        .o_yield_total   (o_res.yield_total),
        .o_block_total   (o_res.block_total),
        .o_wake_total    (o_res.wake_total),
        .o_tick          (o_res.tick),
        .o_ready_count   (o_res.ready_count),
        .o_blocked_count (o_res.blocked_count),
        .o_dead_count    (o_res.dead_count)
    );

endmodule

@@ src/rrts_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrts_ctrl
// Command sequencer: accepts a transaction, steps the datapath, emits result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_fsm r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE:   if (i_in_valid) n_state = FSM_RUN;
            FSM_RUN:    if (i_stat.done) n_state = FSM_FINISH;
            FSM_FINISH: if (out_free) n_state = FSM_IDLE;
            default:    n_state = FSM_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            FSM_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            FSM_RUN: begin
                o_cmd.step = !i_stat.done;
            end
            FSM_FINISH: begin
                o_cmd.emit = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/rrts_dpath.sv @@
// ----------------------------------------------------------------------------
// rrts_dpath
// Task table, slot walker and result register of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_dpath
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int ID_WIDTH  = 16,
    parameter int CW        = 5,
    parameter int PW        = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [3:0]          i_op,
    input  logic [ID_WIDTH-1:0] i_tid,
    output t_stat               o_stat,
    output logic [2:0]          o_status,
    output logic [ID_WIDTH-1:0] o_result_id,
    output logic [ID_WIDTH-1:0] o_current_id,
    output logic [1:0]          o_query_state,
    output logic [CNT_W-1:0]    o_run_count,
    output logic [CNT_W-1:0]    o_yield_total,
    output logic [CNT_W-1:0]    o_block_total,
    output logic [CNT_W-1:0]    o_wake_total,
    output logic [TICK_W-1:0]   o_tick,
    output logic [CW-1:0]       o_ready_count,
    output logic [CW-1:0]       o_blocked_count,
    output logic [CW-1:0]       o_dead_count
);

    // task table
    logic [ID_WIDTH-1:0] slot_id     [MAX_TASKS];
    t_tstate             slot_state  [MAX_TASKS];
    logic [CNT_W-1:0]    slot_runs   [MAX_TASKS];
    logic [CNT_W-1:0]    slot_yields [MAX_TASKS];
    logic [CNT_W-1:0]    slot_blocks [MAX_TASKS];
    logic [CNT_W-1:0]    slot_wakes  [MAX_TASKS];

    // command registers
    t_op                 r_op, n_op;
    logic [ID_WIDTH-1:0] r_tid, n_tid;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_wp, n_wp;
    logic                r_prep, n_prep;
    logic                r_fin, n_fin;
    logic                r_keep, n_keep;
    logic [PW-1:0]       r_newcur, n_newcur;
    t_status             r_sts, n_sts;
    logic [ID_WIDTH-1:0] r_res, n_res;
    t_tstate             r_qs, n_qs;
    logic [CNT_W-1:0]    r_qr, n_qr, r_qy, n_qy, r_qb, n_qb, r_qw, n_qw;

    // scheduler state
    logic [CW-1:0]       r_used, n_used;
    logic                r_cur_valid, n_cur_valid;
    logic [PW-1:0]       r_cur_slot, n_cur_slot;
    logic [ID_WIDTH-1:0] r_cur_id, n_cur_id;
    logic [ID_WIDTH:0]   r_next_id, n_next_id;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [CW-1:0]       r_nr, n_nr, r_nb, n_nb, r_nd, n_nd;

    // registered entry at the walk pointer
    logic [ID_WIDTH-1:0] r_rd_id;
    t_tstate             r_rd_state;
    logic [CNT_W-1:0]    r_rd_runs, r_rd_yld, r_rd_blk, r_rd_wak;

    // single entry write port
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_id;
    t_tstate             wr_state;
    logic [CNT_W-1:0]    wr_runs, wr_yld, wr_blk, wr_wak;

    // state transition for the population counts
    logic                chg;
    t_tstate             chg_from, chg_to;

    logic [CW-1:0]       ptr_nxt;
    logic                at_end;

    assign ptr_nxt  = CW'(r_ptr) + 1'b1;
    assign at_end   = (r_k == r_used);
    assign o_stat.done = r_fin;

    always_comb begin
        n_op = r_op;         n_tid = r_tid;       n_ptr = r_ptr;
        n_k = r_k;           n_wp = r_wp;         n_prep = r_prep;
        n_fin = r_fin;       n_keep = r_keep;     n_newcur = r_newcur;
        n_sts = r_sts;       n_res = r_res;       n_qs = r_qs;
        n_qr = r_qr;         n_qy = r_qy;         n_qb = r_qb;   n_qw = r_qw;
        n_used = r_used;     n_cur_valid = r_cur_valid;
        n_cur_slot = r_cur_slot;                  n_cur_id = r_cur_id;
        n_next_id = r_next_id;                    n_tick = r_tick;
        n_nr = r_nr;         n_nb = r_nb;         n_nd = r_nd;
        wr_en = 1'b0;        wr_addr = r_ptr;
        wr_id = r_rd_id;     wr_state = r_rd_state;
        wr_runs = r_rd_runs; wr_yld = r_rd_yld;   wr_blk = r_rd_blk; wr_wak = r_rd_wak;
        chg = 1'b0;          chg_from = TS_RUNNING; chg_to = TS_RUNNING;

        if (i_cmd.load) begin
            // latch the command and clear the per-command result
            n_op = t_op'(i_op);
            n_tid = i_tid;
            n_ptr = (t_op'(i_op) == OP_YIELD || t_op'(i_op) == OP_BLKCUR) ?
                    r_cur_slot : '0;
            n_k = '0;
            n_wp = '0;
            n_prep = (t_op'(i_op) == OP_YIELD);
            n_fin = 1'b0;
            n_keep = 1'b0;
            n_newcur = '0;
            n_sts = STS_IGNORE;
            n_res = '0;
            n_qs = TS_DEAD;
            n_qr = '0; n_qy = '0; n_qb = '0; n_qw = '0;
        end else if (i_cmd.step) begin
            unique case (r_op)
                OP_CREATE: begin
                    n_fin = 1'b1;
                    if (r_used >= CW'(MAX_TASKS)) begin
                        n_sts = STS_FULL;
                    end else if (r_next_id[ID_WIDTH]) begin
                        n_sts = STS_NOIDS;
                    end else begin
                        wr_en = 1'b1;
                        wr_addr = r_used[PW-1:0];
                        wr_id = r_next_id[ID_WIDTH-1:0];
                        wr_state = TS_READY;
                        wr_runs = '0; wr_yld = '0; wr_blk = '0; wr_wak = '0;
                        chg = 1'b1; chg_from = TS_RUNNING; chg_to = TS_READY;
                        n_used = r_used + 1'b1;
                        n_res = r_next_id[ID_WIDTH-1:0];
                        n_next_id = r_next_id + 1'b1;
                        n_sts = STS_OK;
                    end
                end
                OP_KILL, OP_BLOCK, OP_UNBLOCK, OP_QUERY: begin
                    if (at_end) begin
                        n_fin = 1'b1;
                    end else if (r_rd_id == r_tid) begin
                        n_fin = 1'b1;
                        priority case (r_op)
                            OP_KILL: begin
                                wr_en = 1'b1; wr_state = TS_DEAD;
                                chg = 1'b1; chg_from = r_rd_state; chg_to = TS_DEAD;
                                n_sts = STS_OK;
                            end
                            OP_BLOCK: begin
                                if (r_rd_state != TS_DEAD && r_rd_state != TS_BLOCKED) begin
                                    wr_en = 1'b1; wr_state = TS_BLOCKED;
                                    wr_blk = sat_inc(r_rd_blk);
                                    chg = 1'b1; chg_from = r_rd_state; chg_to = TS_BLOCKED;
                                    n_sts = STS_OK;
                                end
                            end
                            OP_UNBLOCK: begin
                                if (r_rd_state == TS_BLOCKED) begin
                                    wr_en = 1'b1; wr_state = TS_READY;
                                    wr_wak = sat_inc(r_rd_wak);
                                    chg = 1'b1; chg_from = TS_BLOCKED; chg_to = TS_READY;
                                    n_sts = STS_OK;
                                end
                            end
                            default: begin
                                n_qs = r_rd_state;
                                n_qr = r_rd_runs; n_qy = r_rd_yld;
                                n_qb = r_rd_blk;  n_qw = r_rd_wak;
                                n_sts = STS_OK;
                            end
                        endcase
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                        n_k = r_k + 1'b1;
                    end
                end
                OP_BLKCUR: begin
                    n_fin = 1'b1;
                    if (r_cur_valid && r_rd_state != TS_DEAD && r_rd_state != TS_BLOCKED) begin
                        wr_en = 1'b1; wr_state = TS_BLOCKED;
                        wr_blk = sat_inc(r_rd_blk);
                        chg = 1'b1; chg_from = r_rd_state; chg_to = TS_BLOCKED;
                        n_sts = STS_OK;
                    end
                end
                OP_YIELD: begin
                    if (r_prep) begin
                        // return the running task, then start after it
                        n_prep = 1'b0;
                        n_k = '0;
                        if (r_used == '0) begin
                            n_cur_valid = 1'b0;
                            n_sts = STS_NORDY;
                            n_fin = 1'b1;
                        end else begin
                            if (r_cur_valid && r_rd_state == TS_RUNNING) begin
                                wr_en = 1'b1; wr_state = TS_READY;
                                wr_yld = sat_inc(r_rd_yld);
                                chg = 1'b1; chg_from = TS_RUNNING; chg_to = TS_READY;
                            end
                            n_ptr = (r_cur_valid && ptr_nxt != r_used) ?
                                    ptr_nxt[PW-1:0] : '0;
                        end
                    end else if (at_end) begin
                        n_cur_valid = 1'b0;
                        n_sts = STS_NORDY;
                        n_fin = 1'b1;
                    end else if (r_rd_state == TS_READY) begin
                        // dispatch
                        wr_en = 1'b1; wr_state = TS_RUNNING;
                        wr_runs = sat_inc(r_rd_runs);
                        chg = 1'b1; chg_from = TS_READY; chg_to = TS_RUNNING;
                        n_cur_valid = 1'b1;
                        n_cur_slot = r_ptr;
                        n_cur_id = r_rd_id;
                        n_tick = r_tick + 1'b1;
                        n_res = r_rd_id;
                        n_sts = STS_OK;
                        n_fin = 1'b1;
                    end else begin
                        n_ptr = (ptr_nxt != r_used) ? ptr_nxt[PW-1:0] : '0;
                        n_k = r_k + 1'b1;
                    end
                end
                OP_COLLECT: begin
                    if (at_end) begin
                        n_used = r_wp;
                        n_cur_valid = r_keep;
                        n_cur_slot = r_keep ? r_newcur : '0;
                        n_nd = '0;
                        n_sts = STS_OK;
                        n_fin = 1'b1;
                    end else begin
                        // copy a live entry down to the write slot
                        if (r_rd_state != TS_DEAD) begin
                            wr_en = 1'b1;
                            wr_addr = r_wp[PW-1:0];
                            if (r_cur_valid && r_cur_slot == r_ptr) begin
                                n_keep = 1'b1;
                                n_newcur = r_wp[PW-1:0];
                            end
                            n_wp = r_wp + 1'b1;
                        end
                        n_ptr = r_ptr + 1'b1;
                        n_k = r_k + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_used = '0;
                    n_cur_valid = 1'b0;
                    n_cur_slot = '0;
                    n_cur_id = '0;
                    n_next_id = (ID_WIDTH+1)'(1);
                    n_tick = '0;
                    n_nr = '0; n_nb = '0; n_nd = '0;
                    n_sts = STS_OK;
                    n_fin = 1'b1;
                end
                default: begin
                    n_fin = 1'b1;
                end
            endcase

            // adjust population counts for a state change
            if (chg) begin
                unique case (chg_from)
                    TS_READY:   n_nr = n_nr - 1'b1;
                    TS_BLOCKED: n_nb = n_nb - 1'b1;
                    TS_DEAD:    n_nd = n_nd - 1'b1;
                    default:    ;
                endcase
                unique case (chg_to)
                    TS_READY:   n_nr = n_nr + 1'b1;
                    TS_BLOCKED: n_nb = n_nb + 1'b1;
                    TS_DEAD:    n_nd = n_nd + 1'b1;
                    default:    ;
                endcase
            end
        end
    end

    // write the task table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            slot_id[wr_addr]     <= wr_id;
            slot_state[wr_addr]  <= wr_state;
            slot_runs[wr_addr]   <= wr_runs;
            slot_yields[wr_addr] <= wr_yld;
            slot_blocks[wr_addr] <= wr_blk;
            slot_wakes[wr_addr]  <= wr_wak;
        end
    end

    // read the entry at the next walk pointer, forwarding a same-cycle write
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == n_ptr) begin
            r_rd_id    <= wr_id;
            r_rd_state <= wr_state;
            r_rd_runs  <= wr_runs;
            r_rd_yld   <= wr_yld;
            r_rd_blk   <= wr_blk;
            r_rd_wak   <= wr_wak;
        end else begin
            r_rd_id    <= slot_id[n_ptr];
            r_rd_state <= slot_state[n_ptr];
            r_rd_runs  <= slot_runs[n_ptr];
            r_rd_yld   <= slot_yields[n_ptr];
            r_rd_blk   <= slot_blocks[n_ptr];
            r_rd_wak   <= slot_wakes[n_ptr];
        end
    end

    // payload of the current command
    always_ff @(posedge i_clk) begin
        r_op <= n_op;   r_tid <= n_tid;  r_ptr <= n_ptr;   r_k <= n_k;
        r_wp <= n_wp;   r_keep <= n_keep; r_newcur <= n_newcur;
        r_sts <= n_sts; r_res <= n_res;  r_qs <= n_qs;
        r_qr <= n_qr;   r_qy <= n_qy;    r_qb <= n_qb;     r_qw <= n_qw;
        r_cur_slot <= n_cur_slot;        r_cur_id <= n_cur_id;
    end

    // control and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
            r_fin <= 1'b0;
            r_used <= '0;
            r_cur_valid <= 1'b0;
            r_next_id <= (ID_WIDTH+1)'(1);
            r_tick <= '0;
            r_nr <= '0; r_nb <= '0; r_nd <= '0;
        end else begin
            r_prep <= n_prep;
            r_fin <= n_fin;
            r_used <= n_used;
            r_cur_valid <= n_cur_valid;
            r_next_id <= n_next_id;
            r_tick <= n_tick;
            r_nr <= n_nr; r_nb <= n_nb; r_nd <= n_nd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status        <= r_sts;
            o_result_id     <= r_res;
            o_current_id    <= r_cur_valid ? r_cur_id : '0;
            o_query_state   <= r_qs;
            o_run_count     <= r_qr;
            o_yield_total   <= r_qy;
            o_block_total   <= r_qb;
            o_wake_total    <= r_qw;
            o_tick          <= r_tick;
            o_ready_count   <= r_nr;
            o_blocked_count <= r_nb;
            o_dead_count    <= r_nd;
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_TASKS))
        else $error("table fill exceeds capacity");

    a_counts_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CW+2)'(r_nr) + (CW+2)'(r_nb) + (CW+2)'(r_nd)) <= (CW+2)'(r_used))
        else $error("state counts exceed table fill");

    a_cur_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (CW'(r_cur_slot) < r_used))
        else $error("current slot outside table");

    a_dispatch_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_op == OP_YIELD && !r_prep && !at_end && r_rd_state == TS_READY)
        |=> (r_tick == $past(r_tick) + 1'b1) && r_cur_valid)
        else $error("dispatch did not advance tick");

endmodule
